// ===== hdl/lfsa_pkg.sv =====
// shared types and constants for the lowest-free server allocator
package lfsa_pkg;

    localparam int ARRIVAL_W       = 20;
    localparam int NEED_W          = 8;
    localparam int DUR_W           = 16;
    localparam int BUSY_W          = 21;
    localparam int SUM_W           = 14;
    localparam int CFG_W           = 8;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 16;
    localparam int MAX_SERVERS_DEF = 128;

    localparam logic [CFG_W-1:0] SERVERS_RESET = 8'd128;

    // task values seen by every cell while a request is in progress
    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [BUSY_W-1:0]    until_time;
        logic [CFG_W-1:0]     n;
    } bcast_t;

    // token walking down the chain; the count travels beside it
    typedef struct packed {
        logic             valid;
        logic             commit;
        logic [SUM_W-1:0] sum;
    } token_t;

endpackage

// ===== hdl/lfsa_cell.sv =====
// one server slot: busy-until register and one stage of the token chain
module lfsa_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfsa_pkg::bcast_t     bc,
    input  lfsa_pkg::token_t     tok_in,
    input  logic [CNT_W-1:0]     cnt_in,
    output lfsa_pkg::token_t     tok_out,
    output logic [CNT_W-1:0]     cnt_out
);
    import lfsa_pkg::*;

    localparam logic [SUM_W-1:0] ID  = SUM_W'(IDX + 1);
    localparam logic [31:0]      POS = 32'(IDX);

    logic [BUSY_W-1:0] busy_reg, busy_next;
    token_t            tok_reg, tok_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              active;
    logic              free;
    logic              take;

    always_comb
    begin
        active    = {24'd0, bc.n} > POS;
        free      = active && (busy_reg <= BUSY_W'(bc.arrival));
        take      = tok_in.valid && tok_in.commit && free && (cnt_in != '0);
        tok_next  = tok_in;
        cnt_next  = cnt_in;
        busy_next = busy_reg;
        // counting pass
        if (tok_in.valid && !tok_in.commit && free)
        begin
            cnt_next = cnt_in + CNT_W'(1);
        end
        // commit pass: cnt holds how many servers are still wanted
        if (take)
        begin
            busy_next    = bc.until_time;
            cnt_next     = cnt_in - CNT_W'(1);
            tok_next.sum = tok_in.sum + ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

// ===== hdl/lowest_free_server_allocator.sv =====
// Lowest-free server allocator. Each server keeps its busy-until time in a cell of a
// chain of MAX_SERVERS cells. A request starts a token at cell 0 that moves one cell per
// cycle: the first pass counts free servers among those in use; if enough are free a
// second pass claims the lowest-numbered free ones and adds up their ids. The result sits
// in an output register, so a new request is taken while it waits. The user must write
// servers_in_use through cfg_we / cfg_wdata only while no request is in progress; the
// block itself does not enforce this.
module lowest_free_server_allocator #(
    parameter int MAX_SERVERS = lfsa_pkg::MAX_SERVERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lfsa_pkg::CFG_W-1:0]     cfg_wdata,   // servers_in_use
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // arrival_time [19:0], servers_needed [27:20], duration [43:28]
    input  logic [lfsa_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // id_sum [13:0]
    output logic [lfsa_pkg::OUT_DATA_W-1:0] m_tdata,
    // accepted
    output logic                           m_tuser
);
    import lfsa_pkg::*;

    localparam int CW    = $clog2(MAX_SERVERS + 1);
    localparam int CNT_W = (CW > NEED_W) ? CW : NEED_W;

    typedef enum logic [1:0] {
        IDLE,
        BUSY,
        HOLD
    } state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     n_reg;
    logic [ARRIVAL_W-1:0] arrival_reg;
    logic [NEED_W-1:0]    needed_reg;
    logic [BUSY_W-1:0]    until_reg;
    logic                 inject_reg;
    logic                 commit_reg;
    logic                 res_acc_reg;
    logic [SUM_W-1:0]     res_sum_reg;
    logic                 m_tvalid_reg;
    logic                 out_acc_reg;
    logic [SUM_W-1:0]     out_sum_reg;

    bcast_t               bc;
    token_t               tok [0:MAX_SERVERS];
    logic [CNT_W-1:0]     cnt [0:MAX_SERVERS];
    logic [MAX_SERVERS:0] vld_vec;
    logic                 exit_v;
    logic                 enough;
    logic                 out_free;
    logic                 fin;
    logic                 fin_acc;
    logic [SUM_W-1:0]     fin_sum;

    assign bc.arrival    = arrival_reg;
    assign bc.until_time = until_reg;
    assign bc.n          = n_reg;

    assign tok[0].valid  = inject_reg;
    assign tok[0].commit = commit_reg;
    assign tok[0].sum    = '0;
    assign cnt[0]        = commit_reg ? CNT_W'(needed_reg) : '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SERVERS; g++)
        begin : g_cell
            lfsa_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .bc      (bc),
                .tok_in  (tok[g]),
                .cnt_in  (cnt[g]),
                .tok_out (tok[g+1]),
                .cnt_out (cnt[g+1])
            );
        end
        for (g = 0; g <= MAX_SERVERS; g++)
        begin : g_vld
            assign vld_vec[g] = tok[g].valid;
        end
    endgenerate

    always_comb
    begin
        exit_v   = tok[MAX_SERVERS].valid && (state_reg == BUSY);
        enough   = cnt[MAX_SERVERS] >= CNT_W'(needed_reg);
        out_free = !m_tvalid_reg || m_tready;
        // a request finishes on a rejecting count pass or at the end of the commit pass
        fin      = exit_v && (tok[MAX_SERVERS].commit || !enough);
        fin_acc  = tok[MAX_SERVERS].commit;
        fin_sum  = tok[MAX_SERVERS].commit ? tok[MAX_SERVERS].sum : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            n_reg        <= SERVERS_RESET;
            arrival_reg  <= '0;
            needed_reg   <= '0;
            until_reg    <= '0;
            inject_reg   <= 1'b0;
            commit_reg   <= 1'b0;
            res_acc_reg  <= 1'b0;
            res_sum_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            out_acc_reg  <= 1'b0;
            out_sum_reg  <= '0;
        end
        else
        begin
            inject_reg <= 1'b0;
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                n_reg <= cfg_wdata;
            end
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        arrival_reg <= s_tdata[19:0];
                        needed_reg  <= s_tdata[27:20];
                        until_reg   <= BUSY_W'(s_tdata[19:0]) + BUSY_W'(s_tdata[43:28]);
                        inject_reg  <= 1'b1;
                        commit_reg  <= 1'b0;
                        state_reg   <= BUSY;
                    end
                end
                BUSY:
                begin
                    if (exit_v && !fin)
                    begin
                        inject_reg <= 1'b1;
                        commit_reg <= 1'b1;
                    end
                    if (fin)
                    begin
                        res_acc_reg <= fin_acc;
                        res_sum_reg <= fin_sum;
                        if (out_free)
                        begin
                            m_tvalid_reg <= 1'b1;
                            out_acc_reg  <= fin_acc;
                            out_sum_reg  <= fin_sum;
                            state_reg    <= IDLE;
                        end
                        else
                        begin
                            state_reg <= HOLD;
                        end
                    end
                end
                HOLD:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        out_acc_reg  <= res_acc_reg;
                        out_sum_reg  <= res_sum_reg;
                        state_reg    <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(out_sum_reg);
    assign m_tuser  = out_acc_reg;

    // only one token may be in the chain at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) <= 1)
        else $error("more than one token in chain");

    // a token reaching the end of the chain belongs to a request in progress
    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_SERVERS].valid |-> state_reg == BUSY)
        else $error("token left chain outside a request");

    // the commit pass claims exactly the requested number of servers
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        exit_v && tok[MAX_SERVERS].commit |-> cnt[MAX_SERVERS] == '0)
        else $error("commit pass left servers unclaimed");

    // an accepted request starts a counting pass on the next cycle
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> inject_reg && !commit_reg)
        else $error("counting pass not started");

    // a rejection never reports ids
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected result with nonzero id sum");

endmodule

// ===== tb/lfsa_checker.sv =====
// scoreboard for the lowest-free server allocator: predicts each grant and compares results
module lfsa_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lfsa_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lfsa_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lfsa_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             m_tuser,
    output int                               mismatch_count,
    output int                               grants_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfsa_pkg::*;

    localparam logic [BUSY_W:0] BUSY_MAX = {1'b0, {BUSY_W{1'b1}}};

    typedef struct packed {
        logic             accepted;
        logic [SUM_W-1:0] id_sum;
    } grant_t;

    logic [BUSY_W-1:0] busy_until [MAX_SERVERS_DEF];
    logic [CFG_W-1:0]  servers_in_use;
    grant_t            expected_grants [$];
    grant_t            want;

    // claims the lowest free servers for one request and returns the grant
    function automatic grant_t allocate_servers(logic [ARRIVAL_W-1:0] arrival,
                                                logic [NEED_W-1:0] needed,
                                                logic [DUR_W-1:0] dur);
        grant_t            g;
        int                n_active;
        int                free_cnt;
        int                taken;
        int unsigned       sum;
        logic [BUSY_W:0]   until_wide;
        logic [BUSY_W-1:0] until_time;
        g = '0;
        n_active = int'(servers_in_use);
        if (n_active > MAX_SERVERS_DEF)
            n_active = MAX_SERVERS_DEF;
        free_cnt = 0;
        for (int i = 0; i < n_active; i++)
            if (busy_until[i] <= arrival)
                free_cnt++;
        if (free_cnt < int'(needed))
            return g;
        until_wide = {1'b0, arrival} + {{(BUSY_W + 1 - DUR_W){1'b0}}, dur};
        until_time = (until_wide > BUSY_MAX) ? BUSY_MAX[BUSY_W-1:0] : until_wide[BUSY_W-1:0];
        taken = 0;
        sum = 0;
        for (int i = 0; i < n_active && taken < int'(needed); i++)
        begin
            if (busy_until[i] <= arrival)
            begin
                busy_until[i] = until_time;
                sum += i + 1;
                taken++;
            end
        end
        g.accepted = 1'b1;
        g.id_sum = sum[SUM_W-1:0];
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (busy_until[i])
                busy_until[i] = '0;
            servers_in_use = SERVERS_RESET;
            expected_grants.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
                servers_in_use = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_grants = {expected_grants,
                    allocate_servers(s_tdata[ARRIVAL_W-1:0], s_tdata[ARRIVAL_W +: NEED_W],
                                     s_tdata[ARRIVAL_W + NEED_W +: DUR_W])};
            if (m_tvalid && m_tready)
            begin
                if (expected_grants.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: accepted %0d id_sum %0d",
                                 m_tuser, m_tdata[SUM_W-1:0]);
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (m_tuser !== want.accepted || m_tdata[SUM_W-1:0] !== want.id_sum)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: accepted exp %0d got %0d, id_sum exp %0d got %0d",
                                     want.accepted, m_tuser, want.id_sum, m_tdata[SUM_W-1:0]);
                    end
                end
            end
        end
        grants_pending = expected_grants.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the lowest-free server allocator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsa_pkg::*;

    // upper bound for a run of roughly 1100 requests; the run fails if it is reached
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 2 * MAX_SERVERS_DEF + 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 137;
    localparam int ARRIVAL_MAX     = (1 << ARRIVAL_W) - 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int mismatch_count;
    int grants_pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int servers_eff = MAX_SERVERS_DEF;
    int arrival_now = 0;

    always #2 clk = ~clk;

    lowest_free_server_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    lfsa_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .grants_pending (grants_pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_task(input int arr, input int need, input int dur);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[ARRIVAL_W-1:0] = arr[ARRIVAL_W-1:0];
        word[ARRIVAL_W +: NEED_W] = need[NEED_W-1:0];
        word[ARRIVAL_W + NEED_W +: DUR_W] = dur[DUR_W-1:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random_task();
        int roll;
        int cap;
        int need;
        int dur;
        cap = (servers_eff == 0) ? 8 : servers_eff;
        roll = $urandom_range(99);
        if (roll < 5)
            need = 0;
        else if (roll < 10)
            need = $urandom_range(255, cap + 1);
        else if (roll < 22)
            need = $urandom_range(cap, 1);
        else
            need = $urandom_range((cap < 8) ? cap : 8, 1);
        roll = $urandom_range(99);
        if (roll < 2)
            dur = 0;
        else if (roll < 62)
            dur = $urandom_range(3000, 1);
        else if (roll < 87)
            dur = $urandom_range(30000, 3001);
        else
            dur = $urandom_range(65535, 30001);
        // mostly climbing arrivals, with equal and backward steps mixed in
        roll = $urandom_range(99);
        if (roll < 3)
            arrival_now = (arrival_now > 2000) ? arrival_now - $urandom_range(2000, 1)
                                               : arrival_now;
        else if (roll < 11)
            arrival_now = arrival_now;
        else if (roll < 13)
            arrival_now = arrival_now + $urandom_range(20000, 5000);
        else
            arrival_now = arrival_now + $urandom_range(1000, 1);
        if (arrival_now > ARRIVAL_MAX)
            arrival_now = ARRIVAL_MAX;
        send_task(arrival_now, need, dur);
    endtask

    task automatic write_servers(input int value);
        cfg_we <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        servers_eff = (value > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every grant has come back
    task automatic drain_grants();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (grants_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int phase_servers(input int p);
        case (p)
            1:       return 1;
            2:       return 255;
            3:       return 0;
            4:       return 37;
            5:       return $urandom_range(127, 2);
            6:       return 129;
            default: return 128;
        endcase
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at the reset setting of 128 servers
        send_task(0, 0, 0);
        send_task(0, 128, 100);
        send_task(50, 1, 10);
        send_task(100, 129, 10);
        send_task(100, 255, 10);
        send_task(100, 1, 65535);
        send_task(101, 2, 1);
        send_task(102, 3, 10);
        send_task(102, 1, 0);
        send_task(102, 1, 5);
        send_task(60, 1, 1);
        send_task(200, 127, 7);
        send_task(300, 128, 1);
        arrival_now = 400;
        drain_grants();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                write_servers(phase_servers(p));
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_task();
            drain_grants();
        end

        // top of the arrival range, all-ones duration
        send_task(ARRIVAL_MAX, 128, 65535);
        send_task(ARRIVAL_MAX, 1, 1);
        send_task(ARRIVAL_MAX, 0, 65535);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (grants_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && grants_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
